// ===== rtl/indexed_list_with_compaction_macros.svh =====
// Assertion macros shared by the indexed list RTL.
`ifndef INDEXED_LIST_WITH_COMPACTION_MACROS_SVH
`define INDEXED_LIST_WITH_COMPACTION_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define ILC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("indexed list: same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define ILC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("indexed list: next-cycle check failed");
`else
`define ILC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ILC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/ilc_pkg.sv =====
// Shared types, codes and constants of the indexed list block.
package ilc_pkg;

  localparam int DATA_W       = 32;
  localparam int KIND_W       = 3;
  localparam int POS_W        = 6;
  localparam int COUNT_W      = 7;
  localparam int STATUS_W     = 2;
  localparam int CAPACITY_DEF = 64;
  // read-out tree: eight children per node
  localparam int FANIN_LOG    = 3;
  localparam int FANIN        = 1 << FANIN_LOG;

  typedef enum logic [KIND_W-1:0] {
    K_APPEND      = 3'd0,
    K_READ        = 3'd1,
    K_REPLACE     = 3'd2,
    K_REMOVE_AT   = 3'd3,
    K_REMOVE_LAST = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_DONE,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] word_in;
  } in_word_t;

  typedef struct packed {
    logic [DATA_W-1:0]  word_out;
    logic [COUNT_W-1:0] count_after;
    logic [STATUS_W-1:0] status;
  } out_word_t;

  // Command broadcast to every cell of the row
  typedef struct packed {
    logic wr;
    logic shift;
    logic rd;
  } cell_ctl_t;

  // Number of registered levels needed to gather n leaves
  function automatic int tree_levels(input int n);
    int lv;
    int span;
    lv   = 1;
    span = FANIN;
    for (int k = 0; k < 8; k++) begin
      if (span < n) begin
        span = span * FANIN;
        lv++;
      end
    end
    return lv;
  endfunction

endpackage

// ===== rtl/ilc_cell.sv =====
// One storage cell of the list row: holds one word, shifts from its neighbour.
module ilc_cell #(
  parameter int IW  = 6,
  parameter int IDX = 0
) (
  input  logic                       clk,
  input  ilc_pkg::cell_ctl_t         ctl,
  input  logic [IW-1:0]              idx,
  input  logic [ilc_pkg::DATA_W-1:0] word_in,
  input  logic [ilc_pkg::DATA_W-1:0] next_word,
  output logic [ilc_pkg::DATA_W-1:0] word,
  output logic [ilc_pkg::DATA_W-1:0] leaf
);

  logic [ilc_pkg::DATA_W-1:0] word_r;
  logic                       hit;
  logic                       above;

  assign hit   = (idx == IW'(IDX));
  assign above = (IW'(IDX) >= idx);

  // Close the gap from the neighbour, or take a written word
  always_ff @(posedge clk) begin
    if (ctl.shift && above) begin
      word_r <= next_word;
    end else if (ctl.wr && hit) begin
      word_r <= word_in;
    end
  end

  // Offer the stored word to the read-out tree only when addressed
  assign leaf = (ctl.rd && hit) ? word_r : '0;
  assign word = word_r;

endmodule

// ===== rtl/ilc_tree.sv =====
// Registered eight-way OR tree that gathers the addressed cell's word.
module ilc_tree #(
  parameter int N = ilc_pkg::CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic [ilc_pkg::DATA_W-1:0] leaf [N],
  output logic [ilc_pkg::DATA_W-1:0] sum
);

  localparam int LVLS = ilc_pkg::tree_levels(N);
  localparam int NPAD = 1 << (ilc_pkg::FANIN_LOG * LVLS);

  logic [ilc_pkg::DATA_W-1:0] leaf_pad [NPAD];
  logic [ilc_pkg::DATA_W-1:0] node_nxt [LVLS][NPAD];
  logic [ilc_pkg::DATA_W-1:0] node_r   [LVLS][NPAD];

  // Pad the leaf row up to a full tree
  for (genvar i = 0; i < NPAD; i++) begin : g_pad
    if (i < N) begin : g_real
      assign leaf_pad[i] = leaf[i];
    end else begin : g_zero
      assign leaf_pad[i] = '0;
    end
  end

  // Combine eight children per node, one level per register stage
  always_comb begin
    for (int j = 0; j < NPAD; j++) begin
      node_nxt[0][j] = '0;
      if (j < (NPAD >> ilc_pkg::FANIN_LOG)) begin
        for (int c = 0; c < ilc_pkg::FANIN; c++) begin
          node_nxt[0][j] = node_nxt[0][j] | leaf_pad[(ilc_pkg::FANIN * j + c) & (NPAD - 1)];
        end
      end
    end
    for (int k = 1; k < LVLS; k++) begin
      for (int j = 0; j < NPAD; j++) begin
        node_nxt[k][j] = '0;
        if (j < (NPAD >> (ilc_pkg::FANIN_LOG * (k + 1)))) begin
          for (int c = 0; c < ilc_pkg::FANIN; c++) begin
            node_nxt[k][j] = node_nxt[k][j]
                           | node_r[k-1][(ilc_pkg::FANIN * j + c) & (NPAD - 1)];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    node_r <= node_nxt;
  end

  assign sum = node_r[LVLS-1][0];

endmodule

// ===== rtl/indexed_list_with_compaction.sv =====
// Indexed word list with compaction: top level with control, cell row and read-out tree.
//
// An ordered list of up to CAPACITY 32-bit words held in a row of cells, one
// word per cell. Each input word carries one operation (append, read,
// replace, remove at index, remove last) and yields exactly one result word
// with the word read or removed, the count afterwards and a status. Writes and
// the one-place shift of a removal happen in the cycle the item is taken, so
// the list is updated at once; the read word then travels through a
// registered eight-way OR tree of L levels, L = ceil(log8(CAPACITY)), with a
// minimum of one. The result enters the output register once the last tree
// level holds the read word, and the input stays stalled until then, so a
// new item is taken only after the last one's result is loaded; the pace is
// set by the depth of the read-out tree. The output register lets a new item
// enter while the previous result still waits; a further item is held off
// until that result has been taken. Stored words are not cleared at reset and
// need no clearing pass; only entries below the count are ever read.
`include "indexed_list_with_compaction_macros.svh"

module indexed_list_with_compaction #(
  parameter int CAPACITY = ilc_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ilc_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ilc_pkg::out_word_t out_data
);

  localparam int IW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > ilc_pkg::POS_W) ? CW : ilc_pkg::POS_W;
  localparam int LVLS = ilc_pkg::tree_levels(CAPACITY);
  localparam int DW   = $clog2(LVLS + 1);

  ilc_pkg::state_t    state_r, state_nxt;
  logic [DW-1:0]      drain_r, drain_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               acc;
  logic               free;
  logic               load;
  logic               hold_cap;

  ilc_pkg::cell_ctl_t dec_ctl, cell_ctl;
  logic [IW-1:0]      cell_idx;
  logic [CW-1:0]      dec_count;
  ilc_pkg::status_t   dec_status;
  logic               pos_ok;

  logic [ilc_pkg::COUNT_W-1:0]  res_cnt_r;
  ilc_pkg::status_t             res_status_r;
  logic [ilc_pkg::DATA_W-1:0]   res_word_r;
  logic [ilc_pkg::DATA_W-1:0]   tree_sum;
  logic                         out_valid_r, out_valid_nxt;
  ilc_pkg::out_word_t           out_data_r, out_data_nxt;

  logic [ilc_pkg::DATA_W-1:0] cell_word [CAPACITY];
  logic [ilc_pkg::DATA_W-1:0] nxt_word  [CAPACITY];
  logic [ilc_pkg::DATA_W-1:0] cell_leaf [CAPACITY];

  assign acc  = in_valid && !in_stall;
  assign free = !out_valid_r || !out_stall;

  // Decode the operation against the current count
  assign pos_ok = (CMPW'(in_data.position) < CMPW'(count_r));

  always_comb begin
    dec_ctl    = '0;
    cell_idx   = '0;
    dec_count  = count_r;
    dec_status = ilc_pkg::STAT_OK;
    unique case (in_data.kind)
      ilc_pkg::K_APPEND: begin
        if (count_r == CW'(CAPACITY)) begin
          dec_status = ilc_pkg::STAT_FULL;
        end else begin
          dec_ctl.wr = 1'b1;
          cell_idx   = IW'(count_r);
          dec_count  = count_r + CW'(1);
        end
      end
      ilc_pkg::K_READ: begin
        if (pos_ok) begin
          dec_ctl.rd = 1'b1;
          cell_idx   = IW'(in_data.position);
        end else begin
          dec_status = ilc_pkg::STAT_RANGE;
        end
      end
      ilc_pkg::K_REPLACE: begin
        if (pos_ok) begin
          dec_ctl.wr = 1'b1;
          cell_idx   = IW'(in_data.position);
        end else begin
          dec_status = ilc_pkg::STAT_RANGE;
        end
      end
      ilc_pkg::K_REMOVE_AT: begin
        if (pos_ok) begin
          dec_ctl.rd    = 1'b1;
          dec_ctl.shift = 1'b1;
          cell_idx      = IW'(in_data.position);
          dec_count     = count_r - CW'(1);
        end else begin
          dec_status = ilc_pkg::STAT_RANGE;
        end
      end
      ilc_pkg::K_REMOVE_LAST: begin
        if (count_r != '0) begin
          dec_ctl.rd = 1'b1;
          cell_idx   = IW'(count_r - CW'(1));
          dec_count  = count_r - CW'(1);
        end else begin
          dec_status = ilc_pkg::STAT_RANGE;
        end
      end
      default: begin
        dec_status = ilc_pkg::STAT_RANGE;
      end
    endcase
  end

  // Drive the cells only on an accepted word
  assign cell_ctl  = acc ? dec_ctl : '0;
  assign count_nxt = acc ? dec_count : count_r;

  // Row of cells, each but the top one fed by its upper neighbour
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g < CAPACITY - 1) begin : g_link
      assign nxt_word[g] = cell_word[g+1];
    end else begin : g_end
      assign nxt_word[g] = cell_word[g];
    end
    ilc_cell #(
      .IW  (IW),
      .IDX (g)
    ) u_cell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .idx       (cell_idx),
      .word_in   (in_data.word_in),
      .next_word (nxt_word[g]),
      .word      (cell_word[g]),
      .leaf      (cell_leaf[g])
    );
  end

  ilc_tree #(
    .N (CAPACITY)
  ) u_tree (
    .clk  (clk),
    .leaf (cell_leaf),
    .sum  (tree_sum)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ilc_pkg::ST_IDLE: begin
        if (acc) begin
          state_nxt = (LVLS == 1) ? ilc_pkg::ST_DONE : ilc_pkg::ST_DRAIN;
        end
      end
      ilc_pkg::ST_DRAIN: begin
        if (drain_r == DW'(1)) begin
          state_nxt = ilc_pkg::ST_DONE;
        end
      end
      ilc_pkg::ST_DONE: begin
        state_nxt = free ? ilc_pkg::ST_IDLE : ilc_pkg::ST_HOLD;
      end
      ilc_pkg::ST_HOLD: begin
        if (free) begin
          state_nxt = ilc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ilc_pkg::ST_IDLE;
      end
    endcase
  end

  // State outputs
  always_comb begin
    in_stall  = 1'b1;
    load      = 1'b0;
    hold_cap  = 1'b0;
    drain_nxt = drain_r;
    unique case (state_r)
      ilc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (acc) begin
          drain_nxt = DW'(LVLS - 1);
        end
      end
      ilc_pkg::ST_DRAIN: begin
        drain_nxt = drain_r - DW'(1);
      end
      ilc_pkg::ST_DONE: begin
        load     = free;
        hold_cap = !free;
      end
      ilc_pkg::ST_HOLD: begin
        load = free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Assemble the result word for the output register
  always_comb begin
    out_data_nxt             = out_data_r;
    out_valid_nxt            = out_valid_r && out_stall;
    if (load) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.word_out  = (state_r == ilc_pkg::ST_HOLD) ? res_word_r : tree_sum;
      out_data_nxt.count_after = res_cnt_r;
      out_data_nxt.status    = res_status_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ilc_pkg::ST_IDLE;
      drain_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      drain_r     <= drain_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      res_cnt_r    <= ilc_pkg::COUNT_W'(dec_count);
      res_status_r <= dec_status;
    end
    if (hold_cap) begin
      res_word_r <= tree_sum;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  `ILC_ASSERT_NXT(a_busy_after_accept, clk, rst_n, acc, in_stall)
  `ILC_ASSERT_NXT(a_count_only_on_accept, clk, rst_n, !acc, $stable(count_r))
  `ILC_ASSERT_NXT(a_append_grows, clk, rst_n, acc && (in_data.kind == ilc_pkg::K_APPEND) && (count_r != CW'(CAPACITY)), count_r == $past(count_r) + CW'(1))
  `ILC_ASSERT_IMP(a_full_at_capacity, clk, rst_n, out_valid_r && (out_data_r.status == ilc_pkg::STAT_FULL), out_data_r.count_after == ilc_pkg::COUNT_W'(CAPACITY))

endmodule

// ===== bench/ilc_list_checker.sv =====
// Shadow list, result prediction and result comparison for the indexed list bench.
module ilc_list_checker
  import ilc_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_word_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_word_t out_data,
  output int        fail_count,
  output int        pending,
  output int        list_len
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [DATA_W-1:0] shadow_words [CAPACITY];
  int                shadow_count;
  out_word_t         awaited_q [$];

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    fail_count++;
  endtask

  // Apply one operation to the shadow list and build the word it must return
  task automatic apply_list_op(input in_word_t op, output out_word_t res);
    int p;
    res        = '0;
    res.status = STAT_OK;
    p          = int'(op.position);
    case (op.kind)
      K_APPEND: begin
        if (shadow_count >= CAPACITY) begin
          res.status = STAT_FULL;
        end else begin
          shadow_words[shadow_count] = op.word_in;
          shadow_count++;
        end
      end
      K_READ: begin
        if (p >= shadow_count || p >= CAPACITY) res.status = STAT_RANGE;
        else res.word_out = shadow_words[p];
      end
      K_REPLACE: begin
        if (p >= shadow_count || p >= CAPACITY) res.status = STAT_RANGE;
        else shadow_words[p] = op.word_in;
      end
      K_REMOVE_AT: begin
        if (p >= shadow_count || p >= CAPACITY) begin
          res.status = STAT_RANGE;
        end else begin
          res.word_out = shadow_words[p];
          // close the gap: every later entry moves down one place
          for (int i = p; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i + 1];
          shadow_count--;
        end
      end
      K_REMOVE_LAST: begin
        if (shadow_count == 0) begin
          res.status = STAT_RANGE;
        end else begin
          res.word_out = shadow_words[shadow_count - 1];
          shadow_count--;
        end
      end
      default: res.status = STAT_RANGE;
    endcase
    res.count_after = COUNT_W'(shadow_count);
  endtask

  // Compare accepted results first, then predict the word accepted at this edge
  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      shadow_count = 0;
      fail_count   = 0;
      awaited_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_q.size() == 0) begin
          report_mismatch("result with nothing awaited", out_data.word_out, '0);
        end else begin
          want = awaited_q.pop_front();
          if (out_data.word_out !== want.word_out)
            report_mismatch("word_out", out_data.word_out, want.word_out);
          if (out_data.count_after !== want.count_after)
            report_mismatch("count_after", DATA_W'(out_data.count_after),
                            DATA_W'(want.count_after));
          if (out_data.status !== want.status)
            report_mismatch("status", DATA_W'(out_data.status), DATA_W'(want.status));
        end
      end
      if (in_valid && !in_stall) begin
        apply_list_op(in_data, want);
        awaited_q.push_back(want);
      end
    end
    pending  = awaited_q.size();
    list_len = shadow_count;
  end

endmodule

// ===== bench/indexed_list_with_compaction_tb.sv =====
// Stimulus, flow control and verdict for the indexed list block.
module indexed_list_with_compaction_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ilc_pkg::*;

  localparam int CAP           = CAPACITY_DEF;
  localparam int LONG_HOLD     = 150;
  localparam int DRAIN_SLACK   = 20;
  localparam int POS_MAX       = (1 << POS_W) - 1;
  localparam int KIND_SPARE_LO = int'(K_REMOVE_LAST) + 1;
  localparam int KIND_SPARE_HI = (1 << KIND_W) - 1;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;

  int fail_count;
  int pending;
  int list_len;
  int send_idle_pct = 36;
  int recv_idle_pct = 54;
  int hold_ticket   = 0;

  indexed_list_with_compaction #(.CAPACITY(CAP)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  ilc_list_checker #(.CAPACITY(CAP)) list_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending),
    .list_len   (list_len)
  );

  always #5 clk = ~clk;

  // Give up after a generous fixed time
  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off whenever the ticket moves
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_ticket != hold_seen) begin
        hold_seen = hold_ticket;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Offer one word after random idle cycles and hold it until taken
  task automatic send_word(input in_word_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_op(input logic [KIND_W-1:0] k, input int pos,
                         input logic [DATA_W-1:0] w);
    in_word_t op;
    op.kind     = k;
    op.position = POS_W'(pos);
    op.word_in  = w;
    send_word(op);
  endtask

  // Stop offering until every awaited result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Fill the list with random words, then push against the full limit
  task automatic fill_and_overflow();
    while (list_len < CAP) send_op(K_APPEND, $urandom_range(0, POS_MAX), $urandom);
    send_op(K_APPEND, 0, $urandom);
    send_op(K_APPEND, POS_MAX, $urandom);
    send_op(K_READ, CAP - 1, $urandom);
    send_op(K_REPLACE, CAP - 1, $urandom);
    send_op(K_REMOVE_AT, CAP - 1, $urandom);
    send_op(K_REMOVE_AT, 0, $urandom);
    send_op(K_READ, CAP - 2, $urandom);
  endtask

  // Random traffic in bursts that grow, shrink or mix, so the count sweeps its range
  task automatic run_phase(input int n_items);
    int burst_left;
    int mode;
    int r;
    int pos;
    logic [KIND_W-1:0] k;
    burst_left = 0;
    mode       = 0;
    for (int n = 0; n < n_items; n++) begin
      if (burst_left == 0) begin
        mode       = $urandom_range(0, 2);
        burst_left = $urandom_range(4, 60);
      end
      burst_left--;
      r = $urandom_range(0, 99);
      case (mode)
        0: k = (r < 65) ? KIND_W'(K_APPEND) : (r < 85) ? KIND_W'(K_READ) : KIND_W'(K_REPLACE);
        1: k = (r < 35) ? KIND_W'(K_REMOVE_AT) : (r < 60) ? KIND_W'(K_REMOVE_LAST) :
               (r < 80) ? KIND_W'(K_READ) : KIND_W'(K_REPLACE);
        default: begin
          if (r < 3) k = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
          else if (r < 25) k = K_APPEND;
          else if (r < 45) k = K_READ;
          else if (r < 65) k = K_REPLACE;
          else if (r < 82) k = K_REMOVE_AT;
          else k = K_REMOVE_LAST;
        end
      endcase
      // mostly hit stored entries, sometimes any index
      if (list_len > 0 && $urandom_range(0, 99) < 85) pos = $urandom_range(0, list_len - 1);
      else pos = $urandom_range(0, POS_MAX);
      send_op(k, pos, $urandom);
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty list, spare kinds, index limits, replace and both removals
    send_op(K_REMOVE_LAST, 0, 32'h0);
    send_op(K_READ, 0, 32'h0);
    send_op(K_REPLACE, 0, 32'hFFFF_FFFF);
    send_op(K_REMOVE_AT, 0, 32'h0);
    send_op(KIND_W'(KIND_SPARE_LO), 0, 32'h1234_5678);
    send_op(KIND_W'(KIND_SPARE_HI), POS_MAX, 32'hFFFF_FFFF);
    send_op(K_APPEND, POS_MAX, 32'h0000_0000);
    send_op(K_APPEND, 0, 32'hFFFF_FFFF);
    send_op(K_APPEND, 0, 32'hA5A5_A5A5);
    send_op(K_READ, 0, 32'h0);
    send_op(K_READ, 2, 32'h0);
    send_op(K_READ, POS_MAX, 32'h0);
    send_op(K_READ, 3, 32'h0);
    send_op(K_REPLACE, 1, 32'h5A5A_5A5A);
    send_op(K_REPLACE, 3, 32'hDEAD_BEEF);
    send_op(K_READ, 1, 32'h0);
    send_op(K_REMOVE_AT, 0, 32'h0);
    send_op(K_REMOVE_AT, 2, 32'h0);
    send_op(K_READ, 0, 32'h0);
    send_op(K_REMOVE_LAST, 0, 32'h0);
    send_op(K_REMOVE_AT, 0, 32'h0);
    send_op(K_REMOVE_LAST, 0, 32'h0);

    // Sender idles less often than the receiver; hold the receiver off while filling
    hold_ticket <= hold_ticket + 1;
    fill_and_overflow();
    run_phase(110);

    // Roles swapped; pause halfway until the block is empty
    send_idle_pct <= 54;
    recv_idle_pct <= 36;
    run_phase(80);
    wait_drained();
    run_phase(80);

    // Neither side idles
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    fill_and_overflow();
    run_phase(110);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_SLACK) @(negedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
